@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked property, disabled while the active-low reset is low.
`define CDDS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked next-cycle implication, disabled while the active-low reset is low.
`define CDDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/cdds_pkg.sv @@
// Shared types and constants of the camera distance draw sort block.
package cdds_pkg;
    localparam int MaxObjectsDefault = 64;
    localparam int CoordW = 16;
    localparam int DistW  = 36;
    localparam int IdxW   = 6;

    localparam logic OpCamera = 1'b0;
    localparam logic OpObject = 1'b1;

    // One command from the front end to the back end.
    typedef struct packed {
        logic              op;
        logic              frame_end;
        logic              store;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } t_cmd;
endpackage

@@ sv/cdds_front.sv @@
// Front end: accepts items, checks capacity and queues commands for the back end.
module cdds_front #(
    parameter int MAX_OBJECTS = cdds_pkg::MaxObjectsDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  full,
    input  logic                  i_op,
    input  logic [15:0]           i_pos_x,
    input  logic [15:0]           i_pos_y,
    input  logic [15:0]           i_pos_z,
    input  logic                  i_frame_end,
    output logic                  o_cmd_valid,
    output cdds_pkg::t_cmd        o_cmd,
    input  logic                  i_cmd_take
);
    localparam int CntW = $clog2(MAX_OBJECTS + 1);
    logic [CntW-1:0] r_count;
    logic [1:0]      r_fill;
    cdds_pkg::t_cmd  r_q [2];
    logic            r_rd;
    logic            r_wr;
    logic            w_acc;
    logic            w_store;

    assign full    = (r_fill == 2'd2);
    assign w_acc   = i_push && !full;
    assign w_store = (r_count < CntW'(MAX_OBJECTS));
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fill  <= '0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
        end else begin
            if (w_acc) begin
                r_wr <= ~r_wr;
                if (i_op == cdds_pkg::OpCamera || i_frame_end)
                    r_count <= '0;
                else if (w_store)
                    r_count <= r_count + 1'b1;
            end
            if (i_cmd_take && o_cmd_valid) r_rd <= ~r_rd;
            r_fill <= r_fill + {1'b0, w_acc} - {1'b0, i_cmd_take && o_cmd_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wr].op        <= i_op;
            r_q[r_wr].frame_end <= i_frame_end;
            r_q[r_wr].store     <= w_store;
            r_q[r_wr].x         <= i_pos_x;
            r_q[r_wr].y         <= i_pos_y;
            r_q[r_wr].z         <= i_pos_z;
        end
    end
endmodule

@@ sv/cdds_back.sv @@
// Back end: stores objects, computes distances, shaker-sorts them in ordered mode and emits results.
module cdds_back #(
    parameter int MAX_OBJECTS = cdds_pkg::MaxObjectsDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_sort_mode,
    input  logic                  i_cmd_valid,
    input  cdds_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_take,
    output logic                  o_busy,
    output logic                  empty,
    input  logic                  pop,
    output logic [5:0]            o_object_index,
    output logic [35:0]           o_distance_sq,
    output logic                  o_overflow,
    output logic                  o_last
);
    localparam int AW   = $clog2(MAX_OBJECTS);
    localparam int CntW = $clog2(MAX_OBJECTS + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001, S_DIST = 9'b000000010, S_MUL  = 9'b000000100,
        S_SUM   = 9'b000001000, S_LOAD = 9'b000010000, S_FWD  = 9'b000100000,
        S_BWD   = 9'b001000000, S_FLUSH = 9'b010000000, S_EMIT = 9'b100000000
    } t_state;

    t_state r_state;
    logic signed [15:0] r_cam_x, r_cam_y, r_cam_z;
    logic [47:0]  r_coords [MAX_OBJECTS];
    logic [35:0]  r_dist   [MAX_OBJECTS];
    logic [5:0]   r_ord    [MAX_OBJECTS];
    logic [CntW-1:0] r_count, r_n;
    logic         r_ovf, r_mode;
    logic [AW-1:0] r_k, r_lo, r_hi;
    logic         r_moved;
    logic [47:0]  r_rdc;
    logic [33:0]  r_sqx, r_sqy, r_sqz;
    logic         r_ovalid;
    logic [5:0]   r_oidx;
    logic [35:0]  r_odist;
    logic         r_oovf, r_olast;
    logic [35:0]  r_cd, r_md;
    logic [5:0]   r_co, r_mo;

    logic signed [16:0] w_dx, w_dy, w_dz;
    logic [AW-1:0] w_raddr;
    logic         w_flast, w_blast, w_swap;
    logic [35:0]  w_a_d, w_b_d, w_lo_d, w_hi_d;
    logic [5:0]   w_a_o, w_b_o, w_lo_o, w_hi_o;

    assign o_cmd_take = i_cmd_valid && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE) || r_ovalid;
    assign empty = !r_ovalid;
    assign o_object_index = r_oidx;
    assign o_distance_sq  = r_odist;
    assign o_overflow = r_oovf;
    assign o_last = r_olast;

    assign w_dx = 17'(signed'(r_rdc[47:32])) - 17'(r_cam_x);
    assign w_dy = 17'(signed'(r_rdc[31:16])) - 17'(r_cam_y);
    assign w_dz = 17'(signed'(r_rdc[15:0]))  - 17'(r_cam_z);

    // The sort carries one entry in r_cd/r_co and reads its neighbor from the
    // store ahead into r_md/r_mo. The lower of the pair is a, the upper is b.
    assign w_flast = (AW'(r_k + 1'b1) == r_hi);
    assign w_blast = (AW'(r_k - 1'b1) == r_lo);
    assign w_a_d = (r_state == S_BWD) ? r_md : r_cd;
    assign w_a_o = (r_state == S_BWD) ? r_mo : r_co;
    assign w_b_d = (r_state == S_BWD) ? r_cd : r_md;
    assign w_b_o = (r_state == S_BWD) ? r_co : r_mo;
    assign w_swap = w_a_d > w_b_d;
    assign w_lo_d = w_swap ? w_b_d : w_a_d;
    assign w_lo_o = w_swap ? w_b_o : w_a_o;
    assign w_hi_d = w_swap ? w_a_d : w_b_d;
    assign w_hi_o = w_swap ? w_a_o : w_b_o;

    always_comb begin
        case (r_state)
            S_LOAD:  w_raddr = AW'(r_k + 1'b1);
            S_FWD:   w_raddr = w_flast ? AW'(r_k - 1'b1) : AW'(r_k + 2'd2);
            S_BWD:   w_raddr = w_blast ? AW'(r_k + 1'b1) : AW'(r_k - 2'd2);
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_md <= r_dist[w_raddr];
        r_mo <= r_ord[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf <= 1'b0;
            r_ovalid <= 1'b0;
            r_cam_x <= '0; r_cam_y <= '0; r_cam_z <= '0;
        end else begin
            if (pop && r_ovalid && r_state != S_EMIT) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.op == cdds_pkg::OpCamera) begin
                            r_cam_x <= i_cmd.x; r_cam_y <= i_cmd.y; r_cam_z <= i_cmd.z;
                            r_count <= '0;
                            r_ovf <= 1'b0;
                        end else begin
                            if (i_cmd.store) begin
                                r_coords[r_count[AW-1:0]] <= {i_cmd.x, i_cmd.y, i_cmd.z};
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_ovf <= 1'b1;
                            end
                            if (i_cmd.frame_end) begin
                                r_n <= i_cmd.store ? r_count + 1'b1 : r_count;
                                if (!i_cmd.store) r_ovf <= 1'b1;
                                r_mode <= i_sort_mode;
                                r_k <= '0;
                                r_state <= S_DIST;
                            end
                        end
                    end
                end
                S_DIST: begin
                    r_rdc <= r_coords[r_k];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_sqx <= 34'(w_dx) * 34'(w_dx);
                    r_sqy <= 34'(w_dy) * 34'(w_dy);
                    r_sqz <= 34'(w_dz) * 34'(w_dz);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_ord[r_k] <= 6'(r_k);
                    r_dist[r_k] <= r_mode ? 36'(r_sqx) + 36'(r_sqy) + 36'(r_sqz) : '0;
                    if (CntW'(r_k) + 1'b1 == r_n) begin
                        r_k <= '0;
                        r_lo <= '0;
                        r_hi <= AW'(r_n - 1'b1);
                        r_moved <= 1'b0;
                        r_state <= (r_mode && r_n > CntW'(1)) ? S_LOAD : S_EMIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_DIST;
                    end
                end
                S_LOAD: begin
                    r_cd <= r_md;
                    r_co <= r_mo;
                    r_state <= S_FWD;
                end
                S_FWD: begin
                    r_moved <= r_moved | w_swap;
                    if (!w_flast) begin
                        r_dist[r_k] <= w_lo_d;
                        r_ord[r_k] <= w_lo_o;
                        r_cd <= w_hi_d;
                        r_co <= w_hi_o;
                        r_k <= r_k + 1'b1;
                    end else begin
                        // The larger settles at the top; the smaller starts the backward pass.
                        r_dist[r_hi] <= w_hi_d;
                        r_ord[r_hi] <= w_hi_o;
                        r_cd <= w_lo_d;
                        r_co <= w_lo_o;
                        r_hi <= r_k;
                        r_state <= (r_k > r_lo) ? S_BWD : S_FLUSH;
                    end
                end
                S_BWD: begin
                    if (!w_blast) begin
                        r_dist[r_k] <= w_hi_d;
                        r_ord[r_k] <= w_hi_o;
                        r_cd <= w_lo_d;
                        r_co <= w_lo_o;
                        r_k <= r_k - 1'b1;
                        r_moved <= r_moved | w_swap;
                    end else begin
                        // The smaller settles at the bottom; the larger starts the next pass.
                        r_dist[r_lo] <= w_lo_d;
                        r_ord[r_lo] <= w_lo_o;
                        r_cd <= w_hi_d;
                        r_co <= w_hi_o;
                        r_lo <= r_k;
                        r_moved <= 1'b0;
                        if ((r_moved || w_swap) && r_k < r_hi)
                            r_state <= S_FWD;
                        else
                            r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_dist[r_k] <= r_cd;
                    r_ord[r_k] <= r_co;
                    r_k <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ovalid || pop) begin
                        r_ovalid <= 1'b1;
                        r_oidx <= r_ord[r_k];
                        r_odist <= r_dist[r_k];
                        r_oovf <= r_ovf;
                        r_olast <= (CntW'(r_k) + 1'b1 == r_n);
                        if (CntW'(r_k) + 1'b1 == r_n) begin
                            r_count <= '0;
                            r_ovf <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/camera_distance_draw_sort.sv @@
// Top level of the camera distance draw sort block.
// Usage: push a camera item (op 0), then object items (op 1); the object with
// frame_end closes the frame. Input is a queue port (push/full), results a
// queue port (empty/pop) carrying object index, squared distance, overflow and
// last. The sort_mode register is written on its own valid/ready channel,
// which is ready only while the block holds no pending work and no push is offered.
// A two-entry command queue decouples acceptance from processing; the back end
// stores each object in its idle state. Closing a frame runs the distance
// computation for each object (coordinate read, multiply, sum), then in ordered
// mode a load step, the compare-swaps of the shaker sort (one pair per cycle)
// and a write-back of the carried entry, and then emits the results.
// Reset clears camera, count, overflow and the queues; no result is pending.
// When the receiver stalls, the output register holds and emission waits;
// the command queue fills and full rises.
module camera_distance_draw_sort #(
    parameter int MAX_OBJECTS = cdds_pkg::MaxObjectsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_op,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_pos_z,
    input  logic        i_frame_end,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_object_index,
    output logic [35:0] o_distance_sq,
    output logic        o_overflow,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_sort_mode
);
    logic           w_cmd_valid, w_cmd_take, w_busy;
    cdds_pkg::t_cmd w_cmd;
    logic           r_sort_mode;

    assign o_cfg_ready = !w_busy && !w_cmd_valid && !push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sort_mode <= 1'b0;
        else if (i_cfg_valid && o_cfg_ready) r_sort_mode <= i_cfg_sort_mode;
    end

    cdds_front #(.MAX_OBJECTS(MAX_OBJECTS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .full,
        .i_op, .i_pos_x, .i_pos_y, .i_pos_z, .i_frame_end,
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    cdds_back #(.MAX_OBJECTS(MAX_OBJECTS)) u_back (
        .i_clk, .i_rst_n, .i_sort_mode(r_sort_mode),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .o_busy(w_busy), .empty, .pop,
        .o_object_index, .o_distance_sq, .o_overflow, .o_last
    );
endmodule

@@ sv/cdds_checker.sv @@
// Port-level checker for the camera distance draw sort block, with its bind.
`include "assert_macros.svh"
module cdds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [35:0] o_distance_sq,
    input logic        o_last
);
    `CDDS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty, "result dropped")
    `CDDS_ASSERT_NEXT(a_stable, i_clk, i_rst_n, !empty && !pop, $stable(o_distance_sq), "result changed")
    `CDDS_ASSERT_NEXT(a_last, i_clk, i_rst_n, !empty && !pop, $stable(o_last), "last changed")
    `CDDS_ASSERT(a_known, i_clk, i_rst_n, !$isunknown(empty), "empty unknown")
endmodule

bind camera_distance_draw_sort cdds_checker u_chk (
    .i_clk, .i_rst_n, .empty, .pop, .o_distance_sq, .o_last
);
